// ===== design/rtdc_pkg.sv =====
// Package for the RTD code to temperature converter.
// Holds the Q40 fixed-point constants, status and register codes, and a helper.
// No dependencies.
`timescale 1ns / 1ps

package rtdc_pkg;

   // Q40 fixed-point constants; the iteration runs on u = T/100.
   localparam logic signed [63:0] Q_ONE   = 64'sh0000_0100_0000_0000;
   localparam logic        [63:0] Q_CAP   = 64'h4000_0000_0000_0000;
   localparam logic signed [63:0] K_A     = 64'sd429722129484;
   localparam logic signed [63:0] K_B     = -64'sd6349679650;
   localparam logic signed [63:0] K_C     = -64'sd459925714;
   localparam logic signed [63:0] STOP_DU = 64'sd10995117;
   localparam logic signed [63:0] U_LIM   = 64'sh0000_1000_0000_0000;

   // Output temperature limits in millidegrees.
   localparam logic signed [21:0] T_LOW   = -22'sd200000;
   localparam logic signed [21:0] T_HIGH  = 22'sd850000;

   // The divider produces 64 + 40 quotient bits, one per cycle.
   localparam int DIV_BITS = 104;

   // Result status codes.
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_NEG   = 2'd1;
   localparam logic [1:0] STAT_RANGE = 2'd2;
   localparam logic [1:0] STAT_NONE  = 2'd3;

   // Configuration register indexes.
   localparam logic CSR_REF_RES  = 1'b0;
   localparam logic CSR_PGA_GAIN = 1'b1;

   // Magnitude of a two's complement word.
   function automatic logic [63:0] mag64(input logic signed [63:0] v);
      return v[63] ? (64'd0 - 64'(v)) : 64'(v);
   endfunction

endpackage

// ===== design/rtd_code_to_temperature_top.sv =====
// Top level of the RTD code to temperature converter.
// Converts a converter code to PT100 resistance and inverts Callendar-Van Dusen by Newton.
// Depends on rtdc_pkg.
`timescale 1ns / 1ps

// A code is taken when start is high and busy is low. Busy then stays high until the
// cycle in which the result is shown. The result appears for one cycle with rsp_valid
// and cannot be held off. A negative code is answered by the PREP state, and a resistance
// outside 18.52 to 390.481 ohm by the CHECK state that follows it. A valid code is set up
// through the PREP, CHECK, W and U0 states with two divisions, then runs Newton steps, each
// with extra multiplications below 100 ohm, and is then rounded and shown by the RND and
// FIN states. Each step is bounded by the shared bit-serial divider and the shared
// 32x32 multiplier that forms each Q40 product from 32-bit partial products; at most
// MAX_STEPS steps run.
module rtd_code_to_temperature_top #(
   parameter int MAX_STEPS = 50
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic signed [15:0]  req_adc_code,
   output logic                rsp_valid,
   output logic signed [20:0]  rsp_temperature_milli_c,
   output logic [1:0]          rsp_status,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_index,
   input  logic [15:0]         csr_wdata
);
   import rtdc_pkg::*;

   localparam int STEP_W = $clog2(MAX_STEPS + 1);

   // Sequencer states.
   localparam logic [4:0] ST_IDLE  = 5'd0;
   localparam logic [4:0] ST_PREP  = 5'd1;
   localparam logic [4:0] ST_CHECK = 5'd2;
   localparam logic [4:0] ST_MUL   = 5'd3;
   localparam logic [4:0] ST_DIV   = 5'd4;
   localparam logic [4:0] ST_W     = 5'd5;
   localparam logic [4:0] ST_U0    = 5'd6;
   localparam logic [4:0] ST_A     = 5'd7;
   localparam logic [4:0] ST_B     = 5'd8;
   localparam logic [4:0] ST_C     = 5'd9;
   localparam logic [4:0] ST_D     = 5'd10;
   localparam logic [4:0] ST_E     = 5'd11;
   localparam logic [4:0] ST_F     = 5'd12;
   localparam logic [4:0] ST_G     = 5'd13;
   localparam logic [4:0] ST_H     = 5'd14;
   localparam logic [4:0] ST_UPD   = 5'd15;
   localparam logic [4:0] ST_RND   = 5'd16;
   localparam logic [4:0] ST_FIN   = 5'd17;

   logic [4:0]  state_ff, state_in, ret_ff, ret_in;
   logic [15:0] ref_ff, ref_in;
   logic [7:0]  gain_ff, gain_in;
   logic signed [15:0] code_ff, code_in;
   logic [31:0] n_ff, n_in;
   logic [22:0] d_ff, d_in;
   logic        lower_ff, lower_in;
   logic signed [63:0] w_ff, w_in, u_ff, u_in, u2_ff, u2_in, u3_ff, u3_in;
   logic signed [63:0] g_ff, g_in, gp_ff, gp_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [63:0]  ma_ff, ma_in, mb_ff, mb_in;
   logic         mneg_ff, mneg_in;
   logic [127:0] acc_ff, acc_in;
   logic [1:0]   mcnt_ff, mcnt_in;
   logic [168:0] pr_ff, pr_in;
   logic [63:0]  dy_ff, dy_in;
   logic         dneg_ff, dneg_in, dzero_ff, dzero_in;
   logic [6:0]   dcnt_ff, dcnt_in;
   logic [20:0]  tmag_ff, tmag_in;
   logic         tneg_ff, tneg_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic signed [20:0] rsp_temp_ff, rsp_temp_in;
   logic [1:0]   rsp_status_ff, rsp_status_in;

   // Shared unit requests.
   logic               mul_go, div_go;
   logic signed [63:0] mul_a, mul_b, div_a, div_b;

   // Multiplier datapath: one 32x32 partial product per cycle.
   logic [31:0]  ah, bh;
   logic [63:0]  pp;
   logic [127:0] pp_sh;
   logic [63:0]  mul_mag;
   logic signed [63:0] mres;

   assign ah = mcnt_ff[0] ? ma_ff[63:32] : ma_ff[31:0];
   assign bh = mcnt_ff[1] ? mb_ff[63:32] : mb_ff[31:0];
   assign pp = 64'(ah) * 64'(bh);

   always_comb begin
      unique case (mcnt_ff)
         2'd0:    pp_sh = {64'd0, pp};
         2'd3:    pp_sh = {pp, 64'd0};
         default: pp_sh = {32'd0, pp, 32'd0};
      endcase
   end

   // Q40 truncated product, saturated to 2^62 in magnitude.
   assign mul_mag = (|acc_ff[127:102]) ? Q_CAP : {2'b00, acc_ff[101:40]};
   assign mres    = mneg_ff ? -$signed(mul_mag) : $signed(mul_mag);

   // Divider datapath: restoring division, one quotient bit per cycle.
   logic [168:0] pr_sh;
   logic [64:0]  rem_top;
   logic         rem_ge;
   logic [103:0] quot;
   logic         qsat;
   logic [63:0]  div_mag;
   logic signed [63:0] dres;

   assign pr_sh   = {pr_ff[167:0], 1'b0};
   assign rem_top = pr_sh[168:104];
   assign rem_ge  = rem_top >= {1'b0, dy_ff};
   assign quot    = pr_ff[103:0];
   assign qsat    = (|quot[103:63]) || (quot[62] && (|quot[61:0]));
   assign div_mag = qsat ? Q_CAP : {1'b0, quot[62:0]};
   assign dres    = dzero_ff ? 64'sd0 : (dneg_ff ? -$signed(div_mag) : $signed(div_mag));

   // Newton update with clamping and the stop test.
   logic signed [63:0] un_sum, un_c, du_c;
   logic               stop_c;

   assign un_sum = u_ff + dres;
   always_comb begin
      priority if (un_sum > U_LIM) begin
         un_c = U_LIM;
      end else if (un_sum < -U_LIM) begin
         un_c = -U_LIM;
      end else begin
         un_c = un_sum;
      end
   end
   assign du_c   = un_c - u_ff;
   assign stop_c = (du_c < STOP_DU) && (du_c > -STOP_DU);

   // Range checks on the exact rational resistance n / d.
   logic [7:0]  gain_eff;
   logic        lo_fail, hi_fail;
   logic [63:0] u_mag;
   logic [61:0] rnd_c;
   logic signed [21:0] t_c, t_sat;

   assign gain_eff = (gain_ff == 8'd0) ? 8'd1 : gain_ff;
   assign lo_fail  = (48'(n_ff) * 48'd100) < (48'(d_ff) * 48'd1852);
   assign hi_fail  = (48'(n_ff) * 48'd1000) > (48'(d_ff) * 48'd390481);

   // Rounding of u to millidegrees, half away from zero.
   assign u_mag = mag64(u_ff);
   assign rnd_c = 62'(u_mag[44:0]) * 62'd100000 + 62'h0080_0000_0000;
   assign t_c   = tneg_ff ? -$signed({1'b0, tmag_ff}) : $signed({1'b0, tmag_ff});
   always_comb begin
      priority if (t_c < T_LOW) begin
         t_sat = T_LOW;
      end else if (t_c > T_HIGH) begin
         t_sat = T_HIGH;
      end else begin
         t_sat = t_c;
      end
   end

   // Sequencer and next-state logic.
   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      ref_in        = ref_ff;
      gain_in       = gain_ff;
      code_in       = code_ff;
      n_in          = n_ff;
      d_in          = d_ff;
      lower_in      = lower_ff;
      w_in          = w_ff;
      u_in          = u_ff;
      u2_in         = u2_ff;
      u3_in         = u3_ff;
      g_in          = g_ff;
      gp_in         = gp_ff;
      step_in       = step_ff;
      ma_in         = ma_ff;
      mb_in         = mb_ff;
      mneg_in       = mneg_ff;
      acc_in        = acc_ff;
      mcnt_in       = mcnt_ff;
      pr_in         = pr_ff;
      dy_in         = dy_ff;
      dneg_in       = dneg_ff;
      dzero_in      = dzero_ff;
      dcnt_in       = dcnt_ff;
      tmag_in       = tmag_ff;
      tneg_in       = tneg_ff;
      rsp_valid_in  = 1'b0;
      rsp_temp_in   = rsp_temp_ff;
      rsp_status_in = rsp_status_ff;
      mul_go        = 1'b0;
      mul_a         = 64'sd0;
      mul_b         = 64'sd0;
      div_go        = 1'b0;
      div_a         = 64'sd0;
      div_b         = 64'sd0;

      // Configuration transfers.
      if (csr_valid) begin
         unique case (csr_index)
            CSR_REF_RES:  ref_in  = csr_wdata;
            CSR_PGA_GAIN: gain_in = csr_wdata[7:0];
            default:      ref_in  = ref_ff;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               code_in  = req_adc_code;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            if (code_ff[15]) begin
               rsp_valid_in  = 1'b1;
               rsp_temp_in   = 21'sd0;
               rsp_status_in = STAT_NEG;
               state_in      = ST_IDLE;
            end else begin
               n_in     = (32'(code_ff[14:0]) * 32'(ref_ff)) << 1;
               d_in     = 23'(gain_eff) << 15;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (lo_fail || hi_fail) begin
               rsp_valid_in  = 1'b1;
               rsp_temp_in   = 21'sd0;
               rsp_status_in = STAT_RANGE;
               state_in      = ST_IDLE;
            end else begin
               lower_in = 40'(n_ff) < (40'(d_ff) * 40'd100);
               div_go   = 1'b1;
               div_a    = $signed(64'(n_ff));
               div_b    = $signed(64'(d_ff) * 64'd100);
               ret_in   = ST_W;
            end
         end
         ST_MUL: begin
            acc_in  = acc_ff + pp_sh;
            mcnt_in = mcnt_ff + 2'd1;
            if (mcnt_ff == 2'd3) begin
               state_in = ret_ff;
            end
         end
         ST_DIV: begin
            pr_in   = rem_ge ? {rem_top - {1'b0, dy_ff}, pr_sh[103:1], 1'b1} : pr_sh;
            dcnt_in = dcnt_ff + 7'd1;
            if (dcnt_ff == 7'(DIV_BITS - 1)) begin
               state_in = ret_ff;
            end
         end
         ST_W: begin
            // First guess u0 = (R/100 - 1) / a.
            w_in   = dres;
            div_go = 1'b1;
            div_a  = dres - Q_ONE;
            div_b  = K_A;
            ret_in = ST_U0;
         end
         ST_U0: begin
            u_in    = dres;
            step_in = '0;
            mul_go  = 1'b1;
            mul_a   = dres;
            mul_b   = dres;
            ret_in  = ST_A;
         end
         ST_A: begin
            u2_in  = mres;
            mul_go = 1'b1;
            mul_a  = K_A;
            mul_b  = u_ff;
            ret_in = ST_B;
         end
         ST_B: begin
            g_in   = Q_ONE + mres;
            mul_go = 1'b1;
            mul_a  = K_B;
            mul_b  = u2_ff;
            ret_in = ST_C;
         end
         ST_C: begin
            g_in   = g_ff + mres;
            mul_go = 1'b1;
            mul_a  = K_B;
            mul_b  = u_ff;
            ret_in = ST_D;
         end
         ST_D: begin
            gp_in = K_A + (mres <<< 1);
            if (lower_ff) begin
               mul_go = 1'b1;
               mul_a  = u2_ff;
               mul_b  = u_ff;
               ret_in = ST_E;
            end else begin
               div_go = 1'b1;
               div_a  = w_ff - g_ff;
               div_b  = K_A + (mres <<< 1);
               ret_in = ST_UPD;
            end
         end
         ST_E: begin
            // The C term below 0 degrees: c * u^3 * (u - 1).
            u3_in  = mres;
            mul_go = 1'b1;
            mul_a  = mres;
            mul_b  = u_ff - Q_ONE;
            ret_in = ST_F;
         end
         ST_F: begin
            mul_go = 1'b1;
            mul_a  = K_C;
            mul_b  = mres;
            ret_in = ST_G;
         end
         ST_G: begin
            g_in   = g_ff + mres;
            mul_go = 1'b1;
            mul_a  = K_C;
            mul_b  = (u3_ff <<< 2) - u2_ff - (u2_ff <<< 1);
            ret_in = ST_H;
         end
         ST_H: begin
            gp_in  = gp_ff + mres;
            div_go = 1'b1;
            div_a  = w_ff - g_ff;
            div_b  = gp_ff + mres;
            ret_in = ST_UPD;
         end
         ST_UPD: begin
            u_in = un_c;
            if (stop_c || (step_ff == STEP_W'(MAX_STEPS - 1))) begin
               state_in = ST_RND;
            end else begin
               step_in = step_ff + 1'b1;
               mul_go  = 1'b1;
               mul_a   = un_c;
               mul_b   = un_c;
               ret_in  = ST_A;
            end
         end
         ST_RND: begin
            tmag_in  = rnd_c[60:40];
            tneg_in  = u_ff[63];
            state_in = ST_FIN;
         end
         ST_FIN: begin
            rsp_valid_in  = 1'b1;
            rsp_temp_in   = 21'(t_sat);
            rsp_status_in = STAT_OK;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Launch the shared multiplier.
      if (mul_go) begin
         ma_in    = mag64(mul_a);
         mb_in    = mag64(mul_b);
         mneg_in  = mul_a[63] ^ mul_b[63];
         acc_in   = '0;
         mcnt_in  = 2'd0;
         state_in = ST_MUL;
      end

      // Launch the shared divider.
      if (div_go) begin
         pr_in    = {65'd0, mag64(div_a), 40'd0};
         dy_in    = mag64(div_b);
         dneg_in  = div_a[63] ^ div_b[63];
         dzero_in = (div_b == 64'sd0);
         dcnt_in  = 7'd0;
         state_in = ST_DIV;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         ref_ff       <= 16'd1651;
         gain_ff      <= 8'd8;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         ref_ff       <= ref_in;
         gain_ff      <= gain_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      ret_ff        <= ret_in;
      code_ff       <= code_in;
      n_ff          <= n_in;
      d_ff          <= d_in;
      lower_ff      <= lower_in;
      w_ff          <= w_in;
      u_ff          <= u_in;
      u2_ff         <= u2_in;
      u3_ff         <= u3_in;
      g_ff          <= g_in;
      gp_ff         <= gp_in;
      step_ff       <= step_in;
      ma_ff         <= ma_in;
      mb_ff         <= mb_in;
      mneg_ff       <= mneg_in;
      acc_ff        <= acc_in;
      mcnt_ff       <= mcnt_in;
      pr_ff         <= pr_in;
      dy_ff         <= dy_in;
      dneg_ff       <= dneg_in;
      dzero_ff      <= dzero_in;
      dcnt_ff       <= dcnt_in;
      tmag_ff       <= tmag_in;
      tneg_ff       <= tneg_in;
      rsp_temp_ff   <= rsp_temp_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy                    = (state_ff != ST_IDLE);
   assign csr_ready               = 1'b1;
   assign rsp_valid               = rsp_valid_ff;
   assign rsp_temperature_milli_c = rsp_temp_ff;
   assign rsp_status              = rsp_status_ff;

`ifndef SYNTH
   // A result is never shown in consecutive cycles.
   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // An accepted code keeps the block busy in the next cycle.
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("block not busy after a transfer");

   // Error results carry a zero temperature.
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STAT_OK)) |-> (rsp_temperature_milli_c == 21'sd0))
      else $error("nonzero temperature on an error result");

   // The unused status code never appears.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status != STAT_NONE))
      else $error("invalid status code");

   // A result is only produced while the sequencer is working on a code.
   a_result_from_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a code in flight");
`endif

endmodule
